FILE: src/crcfr_pkg.sv
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared constants, types and the CRC-8/MAXIM byte update for the frame
// receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

   localparam logic [7:0] HDR_FIRST   = 8'h55;
   localparam logic [7:0] HDR_SECOND  = 8'hAA;
   localparam logic [7:0] CRC_POLY    = 8'h8C;
   localparam logic [7:0] MIN_PAYLOAD = 8'd5;
   localparam logic [7:0] MAX_PAYLOAD = 8'd32;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CRC_ERR = 2'd1,
      STATUS_LEN_ERR = 2'd2
   } status_type;

   typedef struct packed {
      status_type         status;
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      logic [7:0]         control_flag;
   } result_type;

   // Reflected CRC-8, one byte, LSB first.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (v[0]) begin
            v = (v >> 1) ^ CRC_POLY;
         end else begin
            v = v >> 1;
         end
      end
      return v;
   endfunction

endpackage

FILE: src/crcfr_in_reg.sv
// ----------------------------------------------------------------------------
// crcfr_in_reg
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module crcfr_in_reg
   import crcfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       consume,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       load;

   assign req_ready = !valid_ff || consume;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

FILE: src/crcfr_parser.sv
// ----------------------------------------------------------------------------
// crcfr_parser
// Frame state machine: header hunt, length check, payload capture and
// running CRC-8/MAXIM, one byte per cycle while no finished result is held back.
// ----------------------------------------------------------------------------
module crcfr_parser
   import crcfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] byte_data,
   input  logic       out_free,
   output logic       consume,
   output logic       emit,
   output result_type result
);

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_HDR2  = 3'd1,
      PH_LEN   = 3'd2,
      PH_DATA  = 3'd3,
      PH_CHECK = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  index_ff, index_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] right_ff, right_in;
   logic [7:0]  flag_ff, flag_in;
   logic [8:0]  index_inc;
   logic [7:0]  crc_next;

   assign crc_next  = crc8_update(crc_ff, byte_data);
   assign index_inc = {1'b0, index_ff} + 9'd1;

   always_comb begin
      phase_in  = phase_ff;
      crc_in    = crc_ff;
      length_in = length_ff;
      index_in  = index_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      flag_in   = flag_ff;
      emit      = 1'b0;
      result    = '0;
      unique case (phase_ff)
         PH_HDR2: begin
            if (byte_data == HDR_SECOND) begin
               crc_in   = crc_next;
               phase_in = PH_LEN;
            end else if (byte_data == HDR_FIRST) begin
               crc_in   = crc8_update(8'h00, byte_data);
               phase_in = PH_HDR2;
            end else begin
               crc_in   = 8'h00;
               phase_in = PH_HUNT;
            end
         end
         PH_LEN: begin
            if (byte_data < MIN_PAYLOAD || byte_data > MAX_PAYLOAD) begin
               crc_in        = 8'h00;
               phase_in      = PH_HUNT;
               emit          = 1'b1;
               result.status = STATUS_LEN_ERR;
            end else begin
               crc_in    = crc_next;
               length_in = byte_data;
               index_in  = 8'd0;
               phase_in  = PH_DATA;
            end
         end
         PH_DATA: begin
            case (index_ff)
               8'd0:    left_in[7:0]   = byte_data;
               8'd1:    left_in[15:8]  = byte_data;
               8'd2:    right_in[7:0]  = byte_data;
               8'd3:    right_in[15:8] = byte_data;
               8'd4:    flag_in        = byte_data;
               default: ;
            endcase
            crc_in   = crc_next;
            index_in = index_inc[7:0];
            if (index_inc >= {1'b0, length_ff}) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            emit = 1'b1;
            if (byte_data == crc_ff) begin
               result.status       = STATUS_OK;
               result.left_speed   = left_ff;
               result.right_speed  = right_ff;
               result.control_flag = flag_ff;
            end else begin
               result.status = STATUS_CRC_ERR;
            end
            crc_in   = 8'h00;
            phase_in = PH_HUNT;
         end
         default: begin
            if (byte_data == HDR_FIRST) begin
               crc_in   = crc8_update(8'h00, byte_data);
               phase_in = PH_HDR2;
            end else begin
               crc_in   = 8'h00;
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   // Hold the byte while a result has nowhere to go.
   assign consume = byte_valid && (out_free || !emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         crc_ff    <= 8'h00;
         length_ff <= 8'd0;
         index_ff  <= 8'd0;
         left_ff   <= 16'd0;
         right_ff  <= 16'd0;
         flag_ff   <= 8'd0;
      end else if (consume) begin
         phase_ff  <= phase_in;
         crc_ff    <= crc_in;
         length_ff <= length_in;
         index_ff  <= index_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         flag_ff   <= flag_in;
      end
   end

endmodule

FILE: src/crcfr_out_reg.sv
// ----------------------------------------------------------------------------
// crcfr_out_reg
// Result register: holds one frame result until the receiver takes it.
// ----------------------------------------------------------------------------
module crcfr_out_reg
   import crcfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  result_type         result,
   output logic               out_free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_left_speed,
   output logic signed [15:0] rsp_right_speed,
   output logic [7:0]         rsp_control_flag
);

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = result_ff.status;
   assign rsp_left_speed   = result_ff.left_speed;
   assign rsp_right_speed  = result_ff.right_speed;
   assign rsp_control_flag = result_ff.control_flag;

endmodule

FILE: src/crc8_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc8_frame_receiver
// Framed packet receiver with CRC-8/MAXIM check.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one received byte per item (req_rx_byte). The block hunts
//   for the header 55 AA, reads a length byte and that many payload bytes,
//   then checks the next byte against the running CRC-8/MAXIM.
//   rsp channel: one item per finished frame: status (accepted, checksum
//   mismatch, length out of range), left/right speeds and the control byte.
//   Bytes that complete no frame give no rsp item.
//   Throughput: one byte per cycle while no result is held back (see Stall).
//   The byte sits in an input register, the CRC byte update and phase step
//   run combinationally from it, and a result lands in the output register.
//   Path: a frame's last byte is registered in the input register, and its
//   result in the output register, which drives rsp_valid.
//   Stall: while a result waits in the output register, bytes that finish
//   no frame still flow; a byte that would produce a second result holds in
//   the input register and req_ready drops until rsp_ready frees the slot.
//   Reset: synchronous; the parser returns to header hunt, CRC clears and
//   both registers empty.
// ----------------------------------------------------------------------------
module crc8_frame_receiver
   import crcfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_left_speed,
   output logic signed [15:0] rsp_right_speed,
   output logic [7:0]         rsp_control_flag
);

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       consume;
   logic       emit;
   logic       out_free;
   result_type result;

   crcfr_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .consume     (consume),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   crcfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .out_free   (out_free),
      .consume    (consume),
      .emit       (emit),
      .result     (result)
   );

   crcfr_out_reg u_out_reg (
      .clock            (clock),
      .reset            (reset),
      .load             (consume && emit),
      .result           (result),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_left_speed   (rsp_left_speed),
      .rsp_right_speed  (rsp_right_speed),
      .rsp_control_flag (rsp_control_flag)
   );

endmodule

FILE: tb/crc8_frame_checker.sv
// ----------------------------------------------------------------------------
// crc8_frame_checker
// Watches both channels of the frame receiver, tracks the header hunt, the
// length, the payload and the CRC-8/MAXIM sum itself, and compares every
// response item with the oldest predicted frame result.
// ----------------------------------------------------------------------------
module crc8_frame_checker
   import crcfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_status,
   input  logic signed [15:0] rsp_left_speed,
   input  logic signed [15:0] rsp_right_speed,
   input  logic [7:0]         rsp_control_flag,
   output int                 errors,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      SEEK_FIRST,
      SEEK_SECOND,
      TAKE_LENGTH,
      TAKE_PAYLOAD,
      TAKE_CHECK
   } parse_phase_type;

   parse_phase_type    parse_phase;
   logic [7:0]         frame_crc;
   logic [7:0]         frame_len;
   logic [7:0]         frame_idx;
   logic [15:0]        left_word;
   logic [15:0]        right_word;
   logic [7:0]         flag_word;
   result_type         frame_results[$];

   // Shift the sum one data bit at a time, LSB first.
   function automatic logic [7:0] maxim_crc_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] sum;
      logic       mix;
      sum = crc;
      for (int k = 0; k < 8; k++) begin
         mix = sum[0] ^ data[k];
         sum = {1'b0, sum[7:1]};
         if (mix) begin
            sum = sum ^ CRC_POLY;
         end
      end
      return sum;
   endfunction

   task automatic push_result(input status_type st, input logic [15:0] l,
                              input logic [15:0] r, input logic [7:0] f);
      result_type item;
      item.status       = st;
      item.left_speed   = l;
      item.right_speed  = r;
      item.control_flag = f;
      frame_results.push_back(item);
   endtask

   task automatic parse_byte(input logic [7:0] b);
      case (parse_phase)
         SEEK_SECOND: begin
            if (b == HDR_SECOND) begin
               frame_crc   = maxim_crc_step(frame_crc, b);
               parse_phase = TAKE_LENGTH;
            end else if (b == HDR_FIRST) begin
               frame_crc = maxim_crc_step(8'h00, b);
            end else begin
               frame_crc   = 8'h00;
               parse_phase = SEEK_FIRST;
            end
         end
         TAKE_LENGTH: begin
            if (b < MIN_PAYLOAD || b > MAX_PAYLOAD) begin
               push_result(STATUS_LEN_ERR, 16'h0000, 16'h0000, 8'h00);
               frame_crc   = 8'h00;
               parse_phase = SEEK_FIRST;
            end else begin
               frame_crc   = maxim_crc_step(frame_crc, b);
               frame_len   = b;
               frame_idx   = 8'd0;
               parse_phase = TAKE_PAYLOAD;
            end
         end
         TAKE_PAYLOAD: begin
            case (frame_idx)
               8'd0: left_word[7:0]   = b;
               8'd1: left_word[15:8]  = b;
               8'd2: right_word[7:0]  = b;
               8'd3: right_word[15:8] = b;
               8'd4: flag_word        = b;
               default: ;
            endcase
            frame_crc = maxim_crc_step(frame_crc, b);
            frame_idx = frame_idx + 8'd1;
            if (frame_idx >= frame_len) begin
               parse_phase = TAKE_CHECK;
            end
         end
         TAKE_CHECK: begin
            if (b == frame_crc) begin
               push_result(STATUS_OK, left_word, right_word, flag_word);
            end else begin
               push_result(STATUS_CRC_ERR, 16'h0000, 16'h0000, 8'h00);
            end
            frame_crc   = 8'h00;
            parse_phase = SEEK_FIRST;
         end
         default: begin
            if (b == HDR_FIRST) begin
               frame_crc   = maxim_crc_step(8'h00, b);
               parse_phase = SEEK_SECOND;
            end else begin
               frame_crc = 8'h00;
            end
         end
      endcase
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : track
      result_type want;
      if (reset) begin
         parse_phase = SEEK_FIRST;
         frame_crc   = 8'h00;
         frame_len   = 8'd0;
         frame_idx   = 8'd0;
         left_word   = 16'h0000;
         right_word  = 16'h0000;
         flag_word   = 8'h00;
         errors      = 0;
         frame_results.delete();
      end else begin
         // compare first: a result leaving now belongs to an earlier item
         if (rsp_valid && rsp_ready) begin
            if (frame_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status %0d",
                        $time, rsp_status);
               errors++;
            end else begin
               want = frame_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("left_speed", want.left_speed, rsp_left_speed);
               check_field("right_speed", want.right_speed, rsp_right_speed);
               check_field("control_flag", want.control_flag, rsp_control_flag);
            end
         end
         if (req_valid && req_ready) begin
            parse_byte(req_rx_byte);
         end
      end
      pending = frame_results.size();
   end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams into the frame receiver: a few hand-built frames and
// broken headers, then random frames, bad lengths, corrupted sums, truncated
// frames and noise, with random idling on both sides and one long response
// stall. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import crcfr_pkg::*;

   localparam int BYTE_TARGET = 550;
   localparam int CALM_AFTER  = 470;
   localparam int HOLD_AT     = 120;
   localparam int HOLD_CYCLES = 120;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 6;

   typedef logic [7:0] byte_q_type[$];

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_ready   = 1'b0;
   logic               req_ready;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [15:0] rsp_left_speed;
   logic signed [15:0] rsp_right_speed;
   logic [7:0]         rsp_control_flag;

   int                 errors;
   int                 pending;
   int                 bytes_sent   = 0;
   int                 stall_cycles = 0;
   bit                 calm         = 1'b0;
   bit                 sender_quiet = 1'b0;
   bit                 reader_quiet = 1'b0;
   bit                 hold_done    = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   crc8_frame_receiver u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_left_speed   (rsp_left_speed),
      .rsp_right_speed  (rsp_right_speed),
      .rsp_control_flag (rsp_control_flag)
   );

   crc8_frame_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_left_speed   (rsp_left_speed),
      .rsp_right_speed  (rsp_right_speed),
      .rsp_control_flag (rsp_control_flag),
      .errors           (errors),
      .pending          (pending)
   );

   // End the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Response side: random back-pressure, one long hold once traffic runs.
   initial begin
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) begin
            reader_quiet = !reader_quiet;
         end
         if (!calm && !hold_done && bytes_sent >= HOLD_AT) begin
            rsp_ready <= 1'b0;
            hold_done = 1'b1;
            for (int n = 1; n < HOLD_CYCLES; n++) begin
               @(negedge clock);
            end
         end else if (!calm && !reader_quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic put_byte(input logic [7:0] b);
      if ($urandom_range(0, 99) == 0) begin
         sender_quiet = !sender_quiet;
      end
      if (!calm && !sender_quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (bytes_sent >= CALM_AFTER) begin
         calm = 1'b1;
      end
      @(negedge clock);
   endtask

   task automatic put_bytes(input byte_q_type bytes);
      foreach (bytes[i]) begin
         put_byte(bytes[i]);
      end
   endtask

   // Header, length, payload and sum; a corrupted sum is flipped by a nonzero mask.
   function automatic byte_q_type build_frame(input byte_q_type payload,
                                              input logic [7:0] sum_flip);
      byte_q_type bytes;
      logic [7:0] sum;
      bytes = '{HDR_FIRST, HDR_SECOND, 8'(payload.size())};
      foreach (payload[i]) begin
         bytes.push_back(payload[i]);
      end
      sum = 8'h00;
      foreach (bytes[i]) begin
         sum = crc8_update(sum, bytes[i]);
      end
      bytes.push_back(sum ^ sum_flip);
      return bytes;
   endfunction

   function automatic byte_q_type random_payload(input int len);
      byte_q_type payload;
      for (int i = 0; i < len; i++) begin
         payload.push_back(8'($urandom_range(0, 255)));
      end
      return payload;
   endfunction

   initial begin
      byte_q_type payload;
      byte_q_type noise;
      logic [7:0] flip;
      int         len;
      int         kind;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // stray byte, repeated first header byte, speeds and flag at their extremes
      put_bytes('{HDR_FIRST, 8'h13, HDR_FIRST});
      put_bytes(build_frame('{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF}, 8'h00));
      // lengths just outside the legal range
      put_bytes('{HDR_FIRST, HDR_SECOND, MIN_PAYLOAD - 8'd1});
      put_bytes('{HDR_FIRST, HDR_SECOND, MAX_PAYLOAD + 8'd1});
      // checksum mismatch with one extra payload byte
      put_bytes(build_frame('{8'hFF, 8'h7F, 8'h00, 8'h80, 8'h00, 8'hA5}, 8'h01));

      while (bytes_sent < BYTE_TARGET) begin
         kind = $urandom_range(0, 15);
         if (kind <= 9) begin
            case ($urandom_range(0, 19))
               0:       len = MAX_PAYLOAD;
               1:       len = $urandom_range(9, MAX_PAYLOAD - 1);
               default: len = $urandom_range(MIN_PAYLOAD, 8);
            endcase
            flip = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
            put_bytes(build_frame(random_payload(len), flip));
         end else if (kind <= 11) begin
            if ($urandom_range(0, 1) == 0) begin
               len = $urandom_range(0, MIN_PAYLOAD - 1);
            end else begin
               len = $urandom_range(MAX_PAYLOAD + 1, 255);
            end
            put_bytes('{HDR_FIRST, HDR_SECOND, 8'(len)});
         end else if (kind <= 13) begin
            // noise, with stray first header bytes mixed in
            noise = random_payload($urandom_range(1, 6));
            foreach (noise[i]) begin
               if ($urandom_range(0, 3) == 0) begin
                  noise[i] = HDR_FIRST;
               end
            end
            put_bytes(noise);
         end else if (kind == 14) begin
            // first header byte followed by anything
            put_bytes('{HDR_FIRST, 8'($urandom_range(0, 255))});
         end else begin
            // truncated frame: the next bytes are taken as its payload
            len = $urandom_range(MIN_PAYLOAD, 8);
            payload = random_payload($urandom_range(0, len - 1));
            put_bytes('{HDR_FIRST, HDR_SECOND, 8'(len)});
            put_bytes(payload);
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/crcfr_pkg.sv
src/crcfr_in_reg.sv
src/crcfr_parser.sv
src/crcfr_out_reg.sv
src/crc8_frame_receiver.sv
tb/crc8_frame_checker.sv
tb/testbench.sv
